@@ rtl/hks_pkg.sv @@
// Package for the histogram KS distance block: widths, storage depth and shared types.
// It depends on nothing else; the RAM, the multiplier and the top level import it.
package hks_pkg;

    localparam int MAX_BINS   = 256;
    localparam int ADDR_W     = $clog2(MAX_BINS);
    localparam int CNT_W      = $clog2(MAX_BINS + 1);
    localparam int FLUX_W     = 32;
    localparam int CUM_W      = 40;
    localparam int MUL_B_W    = CUM_W / 2;
    localparam int PROD_W     = CUM_W + MUL_B_W;
    localparam int WIDE_W     = 2 * CUM_W;
    localparam int FRAC_W     = 16;
    localparam int KS_W       = FRAC_W + 1;
    localparam int SUM_W      = 64;
    localparam int IN_DATA_W  = 2 * FLUX_W;
    localparam int OUT_PACK_W = KS_W + CUM_W + 2 * SUM_W;
    localparam int OUT_DATA_W = ((OUT_PACK_W + 7) / 8) * 8;
    localparam int OUT_USER_W = 2;
    localparam int DIV_CNT_W  = $clog2(FRAC_W);

    typedef logic [CUM_W-1:0]  cum_t;
    typedef logic [WIDE_W-1:0] wide_t;
    typedef logic [SUM_W-1:0]  sum_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        cum_t              cum_a;
        cum_t              cum_b;
    } ram_wr_t;

endpackage

@@ rtl/hks_bin_ram.sv @@
// Prefix sum memory for both histograms, one write port and one registered read port.
// Depends on hks_pkg for the depth, the word width and the write port struct.
module hks_bin_ram (
    input  logic                      clk,
    input  hks_pkg::ram_wr_t          wr,
    input  logic [hks_pkg::ADDR_W-1:0] raddr,
    output hks_pkg::cum_t             rdata_a,
    output hks_pkg::cum_t             rdata_b
);
    import hks_pkg::*;

    cum_t cum_a_store [MAX_BINS];
    cum_t cum_b_store [MAX_BINS];

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            cum_a_store[wr.addr] <= wr.cum_a;
            cum_b_store[wr.addr] <= wr.cum_b;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_a <= cum_a_store[raddr];
        rdata_b <= cum_b_store[raddr];
    end

endmodule

@@ rtl/hks_mul.sv @@
// Shared multiplier of 40 by 20 bits with a registered product.
// Depends on hks_pkg for its operand and product widths.
module hks_mul (
    input  logic                        clk,
    input  hks_pkg::cum_t               op_a,
    input  logic [hks_pkg::MUL_B_W-1:0] op_b,
    output logic [hks_pkg::PROD_W-1:0]  prod
);
    import hks_pkg::*;

    always_ff @(posedge clk)
    begin
        prod <= PROD_W'(op_a) * PROD_W'(op_b);
    end

endmodule

@@ rtl/histogram_ks_distance.sv @@
// Top level of the histogram KS distance block: handshakes, prefix sums and the sequencer.
// Depends on hks_pkg, hks_bin_ram and hks_mul.
//
// Channel  Direction  Contents
// s_axis   in         tdata: flux_a, flux_b; tlast: last_bin; tuser: first_of_frame
// m_axis   out        tdata: ks_distance, pixel_weight, weighted_sum, weight_total;
//                     tuser: empty_flag, bin_overflow
//
// A bin that is not the last of its pixel is taken in S_IDLE and leaves the sequencer idle.
// After a last bin the input waits for the denominator and a walk over the n stored bins:
// four passes of every bin through the single 40x20 multiplier, then the merge, the difference
// and the compare; a distance of one skips the division, an empty histogram goes to the sums.
// Reset clears the sequencer, the prefix sums, the bin count and the frame sums.
// The result waits in an output register, so a stalled output holds only the next last bin.
module histogram_ks_distance (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // flux_a [31:0], flux_b [63:32]
    input  logic [hks_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    input  logic                            s_axis_tlast,
    // first_of_frame [0]
    input  logic [0:0]                      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // ks_distance [16:0], pixel_weight [56:17], weighted_sum [120:57],
    // weight_total [184:121], zero fill above
    output logic [hks_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // empty_flag [0], bin_overflow [1]
    output logic [hks_pkg::OUT_USER_W-1:0]  m_axis_tuser
);
    import hks_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DEN_LO   = 4'd1;
    localparam logic [3:0] S_DEN_HI   = 4'd2;
    localparam logic [3:0] S_DEN_END  = 4'd3;
    localparam logic [3:0] S_X_LO     = 4'd4;
    localparam logic [3:0] S_X_HI     = 4'd5;
    localparam logic [3:0] S_Y_LO     = 4'd6;
    localparam logic [3:0] S_Y_HI     = 4'd7;
    localparam logic [3:0] S_Y_END    = 4'd8;
    localparam logic [3:0] S_ABS      = 4'd9;
    localparam logic [3:0] S_MAX      = 4'd10;
    localparam logic [3:0] S_DIV_INIT = 4'd11;
    localparam logic [3:0] S_DIV      = 4'd12;
    localparam logic [3:0] S_WS_MUL   = 4'd13;
    localparam logic [3:0] S_WS_ADD   = 4'd14;
    localparam logic [3:0] S_DONE     = 4'd15;

    localparam logic [KS_W-1:0] KS_ONE = KS_W'(1) << FRAC_W;
    localparam cum_t CUM_MAX = '1;
    localparam sum_t SUM_MAX = '1;

    logic [3:0]            state_reg, state_next;
    cum_t                  cum_a_reg, cum_a_next;
    cum_t                  cum_b_reg, cum_b_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  ovf_seen_reg, ovf_seen_next;
    sum_t                  fw_acc_reg, fw_acc_next;
    sum_t                  fwt_acc_reg, fwt_acc_next;
    cum_t                  ta_reg, ta_next;
    cum_t                  tb_reg, tb_next;
    logic [CNT_W-1:0]      n_reg, n_next;
    logic                  empty_reg, empty_next;
    logic                  ovf_reg, ovf_next;
    logic [ADDR_W-1:0]     k_reg, k_next;
    logic [PROD_W-1:0]     acc_reg, acc_next;
    wide_t                 den_reg, den_next;
    wide_t                 x_reg, x_next;
    wide_t                 y_reg, y_next;
    wide_t                 d_reg, d_next;
    wide_t                 best_reg, best_next;
    wide_t                 rem_reg, rem_next;
    logic [KS_W-1:0]       ks_reg, ks_next;
    logic [DIV_CNT_W-1:0]  div_cnt_reg, div_cnt_next;
    logic                  m_valid_reg, m_valid_next;
    logic [OUT_DATA_W-1:0] m_data_reg, m_data_next;
    logic [OUT_USER_W-1:0] m_user_reg, m_user_next;

    logic                  in_fire;
    logic                  full;
    logic [CUM_W:0]        sum_a, sum_b;
    cum_t                  sat_a, sat_b;
    ram_wr_t               ram_wr;
    cum_t                  rd_a, rd_b;
    cum_t                  mul_a;
    logic [MUL_B_W-1:0]    mul_b;
    logic [PROD_W-1:0]     mul_p;
    wide_t                 wide_prod;
    logic [WIDE_W:0]       rem_shift;
    logic [WIDE_W:0]       rem_diff;
    logic [SUM_W:0]        fw_sum, fwt_sum;
    logic                  last_k;

    hks_bin_ram u_ram (
        .clk     (clk),
        .wr      (ram_wr),
        .raddr   (k_next),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    hks_mul u_mul (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (mul_p)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign full          = (count_reg == CNT_W'(MAX_BINS));

    assign sum_a = {1'b0, cum_a_reg} + (CUM_W + 1)'(s_axis_tdata[FLUX_W-1:0]);
    assign sum_b = {1'b0, cum_b_reg} + (CUM_W + 1)'(s_axis_tdata[2*FLUX_W-1:FLUX_W]);
    assign sat_a = sum_a[CUM_W] ? CUM_MAX : sum_a[CUM_W-1:0];
    assign sat_b = sum_b[CUM_W] ? CUM_MAX : sum_b[CUM_W-1:0];

    assign ram_wr.we    = in_fire && !full;
    assign ram_wr.addr  = count_reg[ADDR_W-1:0];
    assign ram_wr.cum_a = sat_a;
    assign ram_wr.cum_b = sat_b;

    assign wide_prod = WIDE_W'(acc_reg) + (WIDE_W'(mul_p) << MUL_B_W);
    assign rem_shift = {rem_reg, 1'b0};
    assign rem_diff  = rem_shift - {1'b0, den_reg};
    assign fw_sum    = {1'b0, fw_acc_reg} + (SUM_W + 1)'(mul_p);
    assign fwt_sum   = {1'b0, fwt_acc_reg} + (SUM_W + 1)'(ta_reg);
    assign last_k    = ((CNT_W'(k_reg) + CNT_W'(1)) == n_reg);

    always_comb
    begin
        mul_a = ta_reg;
        mul_b = tb_reg[MUL_B_W-1:0];
        case (state_reg)
            S_DEN_HI:
            begin
                mul_b = tb_reg[CUM_W-1:MUL_B_W];
            end
            S_X_LO:
            begin
                mul_a = rd_a;
            end
            S_X_HI:
            begin
                mul_a = rd_a;
                mul_b = tb_reg[CUM_W-1:MUL_B_W];
            end
            S_Y_LO:
            begin
                mul_a = rd_b;
                mul_b = ta_reg[MUL_B_W-1:0];
            end
            S_Y_HI:
            begin
                mul_a = rd_b;
                mul_b = ta_reg[CUM_W-1:MUL_B_W];
            end
            S_WS_MUL:
            begin
                mul_b = {{(MUL_B_W - KS_W){1'b0}}, ks_reg};
            end
            default:
            begin
                mul_a = ta_reg;
            end
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        cum_a_next    = cum_a_reg;
        cum_b_next    = cum_b_reg;
        count_next    = count_reg;
        ovf_seen_next = ovf_seen_reg;
        fw_acc_next   = fw_acc_reg;
        fwt_acc_next  = fwt_acc_reg;
        ta_next       = ta_reg;
        tb_next       = tb_reg;
        n_next        = n_reg;
        empty_next    = empty_reg;
        ovf_next      = ovf_reg;
        k_next        = k_reg;
        acc_next      = acc_reg;
        den_next      = den_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        d_next        = d_reg;
        best_next     = best_reg;
        rem_next      = rem_reg;
        ks_next       = ks_reg;
        div_cnt_next  = div_cnt_reg;
        m_valid_next  = m_valid_reg && !m_axis_tready;
        m_data_next   = m_data_reg;
        m_user_next   = m_user_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (s_axis_tuser[0])
                    begin
                        fw_acc_next  = '0;
                        fwt_acc_next = '0;
                    end
                    if (!full)
                    begin
                        cum_a_next = sat_a;
                        cum_b_next = sat_b;
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        ovf_seen_next = 1'b1;
                    end
                    if (s_axis_tlast)
                    begin
                        ta_next       = cum_a_next;
                        tb_next       = cum_b_next;
                        n_next        = count_next;
                        ovf_next      = ovf_seen_next;
                        empty_next    = (cum_a_next == '0) || (cum_b_next == '0);
                        cum_a_next    = '0;
                        cum_b_next    = '0;
                        count_next    = '0;
                        ovf_seen_next = 1'b0;
                        k_next        = '0;
                        best_next     = '0;
                        ks_next       = '0;
                        if (empty_next)
                        begin
                            state_next = S_WS_MUL;
                        end
                        else
                        begin
                            state_next = S_DEN_LO;
                        end
                    end
                end
            end
            S_DEN_LO:
            begin
                state_next = S_DEN_HI;
            end
            S_DEN_HI:
            begin
                acc_next   = mul_p;
                state_next = S_DEN_END;
            end
            S_DEN_END:
            begin
                den_next   = wide_prod;
                state_next = S_X_LO;
            end
            S_X_LO:
            begin
                state_next = S_X_HI;
            end
            S_X_HI:
            begin
                acc_next   = mul_p;
                state_next = S_Y_LO;
            end
            S_Y_LO:
            begin
                x_next     = wide_prod;
                state_next = S_Y_HI;
            end
            S_Y_HI:
            begin
                acc_next   = mul_p;
                state_next = S_Y_END;
            end
            S_Y_END:
            begin
                y_next     = wide_prod;
                state_next = S_ABS;
            end
            S_ABS:
            begin
                d_next     = (x_reg >= y_reg) ? (x_reg - y_reg) : (y_reg - x_reg);
                state_next = S_MAX;
            end
            S_MAX:
            begin
                if (d_reg > best_reg)
                begin
                    best_next = d_reg;
                end
                if (last_k)
                begin
                    state_next = S_DIV_INIT;
                end
                else
                begin
                    k_next     = k_reg + ADDR_W'(1);
                    state_next = S_X_LO;
                end
            end
            S_DIV_INIT:
            begin
                rem_next     = best_reg;
                div_cnt_next = '0;
                if (best_reg >= den_reg)
                begin
                    ks_next    = KS_ONE;
                    state_next = S_WS_MUL;
                end
                else
                begin
                    ks_next    = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (!rem_diff[WIDE_W])
                begin
                    rem_next = rem_diff[WIDE_W-1:0];
                    ks_next  = {ks_reg[KS_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_shift[WIDE_W-1:0];
                    ks_next  = {ks_reg[KS_W-2:0], 1'b0};
                end
                div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
                if (div_cnt_reg == DIV_CNT_W'(FRAC_W - 1))
                begin
                    state_next = S_WS_MUL;
                end
            end
            S_WS_MUL:
            begin
                state_next = S_WS_ADD;
            end
            S_WS_ADD:
            begin
                fw_acc_next  = fw_sum[SUM_W] ? SUM_MAX : fw_sum[SUM_W-1:0];
                fwt_acc_next = fwt_sum[SUM_W] ? SUM_MAX : fwt_sum[SUM_W-1:0];
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = OUT_DATA_W'({fwt_acc_reg, fw_acc_reg, ta_reg, ks_reg});
                    m_user_next  = {ovf_reg, empty_reg};
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cum_a_reg    <= '0;
            cum_b_reg    <= '0;
            count_reg    <= '0;
            ovf_seen_reg <= 1'b0;
            fw_acc_reg   <= '0;
            fwt_acc_reg  <= '0;
            div_cnt_reg  <= '0;
            k_reg        <= '0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cum_a_reg    <= cum_a_next;
            cum_b_reg    <= cum_b_next;
            count_reg    <= count_next;
            ovf_seen_reg <= ovf_seen_next;
            fw_acc_reg   <= fw_acc_next;
            fwt_acc_reg  <= fwt_acc_next;
            div_cnt_reg  <= div_cnt_next;
            k_reg        <= k_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ta_reg     <= ta_next;
        tb_reg     <= tb_next;
        n_reg      <= n_next;
        empty_reg  <= empty_next;
        ovf_reg    <= ovf_next;
        acc_reg    <= acc_next;
        den_reg    <= den_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        d_reg      <= d_next;
        best_reg   <= best_next;
        rem_reg    <= rem_next;
        ks_reg     <= ks_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

endmodule
